// File: sv/sv39pte_pkg.sv
// ----------------------------------------------------------------------------
// sv39pte_pkg
// shared types, sizes and codes of the sv39 page table engine
// ----------------------------------------------------------------------------
`default_nettype none

package sv39pte_pkg;

  localparam int TABLE_PAGES       = 8;
  localparam int ENTRIES_PER_TABLE = 512;
  localparam int TOP_LEVEL         = 2;

  localparam int VPN_W   = $clog2(ENTRIES_PER_TABLE);
  localparam int PAGE_W  = (TABLE_PAGES > 1) ? $clog2(TABLE_PAGES) : 1;
  localparam int ADDR_W  = PAGE_W + VPN_W;
  localparam int DEPTH   = TABLE_PAGES * ENTRIES_PER_TABLE;
  localparam int CNT_W   = $clog2(TABLE_PAGES + 1);
  localparam int LEVEL_W = 2;
  localparam int PPN_W   = 44;
  localparam int VA_W    = 39;
  localparam int PA_W    = 56;
  localparam int OFS_W   = 12;
  localparam int FLAG_W  = 9;
  localparam int PTE_W   = 64;

  localparam logic [1:0] OP_TRANSLATE = 2'd0;
  localparam logic [1:0] OP_MAP       = 2'd1;
  localparam logic [1:0] OP_UNMAP     = 2'd2;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_UNMAPPED = 2'd1;
  localparam logic [1:0] ST_NOPAGE   = 2'd2;
  localparam logic [1:0] ST_OUTSIDE  = 2'd3;

  typedef struct packed {
    logic [1:0]        operation;
    logic [VA_W-1:0]   virt_addr;
    logic [PA_W-1:0]   phys_addr_in;
    logic [FLAG_W-1:0] perm_flags;
  } in_item_t;

  typedef struct packed {
    logic [1:0]      status;
    logic [PA_W-1:0] phys_addr_out;
  } out_item_t;

  // stored entry: epoch tag of its table page plus the pte itself
  typedef struct packed {
    logic             tag;
    logic [PTE_W-1:0] pte;
  } pte_entry_t;

  typedef struct packed {
    logic              en;
    logic              we;
    logic [ADDR_W-1:0] addr;
    pte_entry_t        data;
  } mem_req_t;

endpackage

`default_nettype wire

// File: sv/sv39_page_table_engine_core.sv
// ----------------------------------------------------------------------------
// sv39_page_table_engine_core
// three level sv39 page table held in an internal store of table pages
//
//   channel  ports                          handshake
//   request  start, busy, in_item           taken when start && !busy
//   result   out_strobe, out_item           one cycle strobe, no back pressure
//   config   cfg_valid, cfg_ready, cfg_data written when cfg_valid && cfg_ready
//
// each level costs a memory read state plus a check state on the single port
// store, but map and unmap write the leaf in the read state of the last level
// (a table allocation adds no state; an early error ends the walk sooner)
// after reset a sweep clears all 4096 entries, busy stays high meanwhile
// one request at a time; results cannot be stalled
// ----------------------------------------------------------------------------
`default_nettype none

module sv39_page_table_engine_core (
  input  wire                      clk,
  input  wire                      rst_n,
  input  wire                      start,
  output logic                     busy,
  input  sv39pte_pkg::in_item_t    in_item,
  output logic                     out_strobe,
  output sv39pte_pkg::out_item_t   out_item,
  input  wire                      cfg_valid,
  output logic                     cfg_ready,
  input  wire [43:0]               cfg_data
);
  import sv39pte_pkg::*;

  logic [PPN_W-1:0] table_base_ppn_r;
  logic [PPN_W-1:0] table_base_ppn_nxt;
  mem_req_t         mem_req;
  pte_entry_t       rd_data;
  logic             init_done;

  assign cfg_ready          = 1'b1;
  assign table_base_ppn_nxt = (cfg_valid && cfg_ready) ? cfg_data : table_base_ppn_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      table_base_ppn_r <= '0;
    end else begin
      table_base_ppn_r <= table_base_ppn_nxt;
    end
  end

  sv39pte_store u_store (
    .clk       (clk),
    .rst_n     (rst_n),
    .mem_req   (mem_req),
    .rd_data   (rd_data),
    .init_done (init_done)
  );

  sv39pte_walker u_walker (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_item        (in_item),
    .out_strobe     (out_strobe),
    .out_item       (out_item),
    .table_base_ppn (table_base_ppn_r),
    .init_done      (init_done),
    .mem_req        (mem_req),
    .rd_data        (rd_data)
  );

endmodule

`default_nettype wire

// File: sv/sv39pte_store.sv
// ----------------------------------------------------------------------------
// sv39pte_store
// single port pte memory with registered read and a clearing sweep after reset
// ----------------------------------------------------------------------------
`default_nettype none

module sv39pte_store (
  input  wire                      clk,
  input  wire                      rst_n,
  input  sv39pte_pkg::mem_req_t    mem_req,
  output sv39pte_pkg::pte_entry_t  rd_data,
  output logic                     init_done
);
  import sv39pte_pkg::*;

  localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(DEPTH - 1);

  pte_entry_t        mem [DEPTH];
  pte_entry_t        rd_data_r;
  logic [ADDR_W-1:0] clr_addr_r;
  logic [ADDR_W-1:0] clr_addr_nxt;
  logic              init_done_r;
  logic              init_done_nxt;

  always_comb begin
    clr_addr_nxt  = clr_addr_r;
    init_done_nxt = init_done_r;
    if (!init_done_r) begin
      clr_addr_nxt = clr_addr_r + 1'b1;
      if (clr_addr_r == LAST_ADDR) begin
        init_done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_addr_r  <= '0;
      init_done_r <= 1'b0;
    end else begin
      clr_addr_r  <= clr_addr_nxt;
      init_done_r <= init_done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!init_done_r) begin
      mem[clr_addr_r] <= '0;
    end else if (mem_req.en && mem_req.we) begin
      mem[mem_req.addr] <= mem_req.data;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_req.en && !mem_req.we) begin
      rd_data_r <= mem[mem_req.addr];
    end
  end

  assign rd_data   = rd_data_r;
  assign init_done = init_done_r;

endmodule

`default_nettype wire

// File: sv/sv39pte_walker.sv
// ----------------------------------------------------------------------------
// sv39pte_walker
// walk sequencer: level reads, table allocation, leaf update and result
// ----------------------------------------------------------------------------
`default_nettype none

module sv39pte_walker (
  input  wire                      clk,
  input  wire                      rst_n,
  input  wire                      start,
  output logic                     busy,
  input  sv39pte_pkg::in_item_t    in_item,
  output logic                     out_strobe,
  output sv39pte_pkg::out_item_t   out_item,
  input  wire [43:0]               table_base_ppn,
  input  wire                      init_done,
  output sv39pte_pkg::mem_req_t    mem_req,
  input  sv39pte_pkg::pte_entry_t  rd_data
);
  import sv39pte_pkg::*;

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_READ  = 2'd1;
  localparam logic [1:0] S_CHECK = 2'd2;

  localparam logic [CNT_W-1:0]   POOL_END  = CNT_W'(TABLE_PAGES);
  localparam logic [PPN_W-1:0]   PAGES_PPN = PPN_W'(TABLE_PAGES);
  localparam logic [LEVEL_W-1:0] LVL_TOP   = LEVEL_W'(TOP_LEVEL);

  logic [1:0]             state_r,   state_nxt;
  logic [1:0]             op_r,      op_nxt;
  logic [VA_W-1:0]        va_r,      va_nxt;
  logic [PPN_W-1:0]       pa_ppn_r,  pa_ppn_nxt;
  logic [FLAG_W-1:0]      flags_r,   flags_nxt;
  logic [LEVEL_W-1:0]     level_r,   level_nxt;
  logic [PAGE_W-1:0]      page_r,    page_nxt;
  logic [CNT_W-1:0]       nf_r,      nf_nxt;
  logic [TABLE_PAGES-1:0] epoch_r,   epoch_nxt;
  logic                   out_strobe_r, out_strobe_nxt;
  out_item_t              out_item_r,   out_item_nxt;

  logic               accept;
  logic [VPN_W-1:0]   vpn_sel;
  logic               cur_epoch;
  logic [PTE_W-1:0]   cur_pte;
  logic [PPN_W-1:0]   pte_ppn;
  logic [PPN_W-1:0]   ppn_diff;
  logic               outside;
  logic [PAGE_W-1:0]  nf_page;
  logic               pool_empty;
  logic [PTE_W-1:0]   alloc_pte;
  logic [PTE_W-1:0]   leaf_pte;

  assign accept = start && !busy;
  assign busy   = (state_r != S_IDLE) || !init_done;

  always_comb begin
    case (level_r)
      2'd2:    vpn_sel = va_r[38:30];
      2'd1:    vpn_sel = va_r[29:21];
      default: vpn_sel = va_r[20:12];
    endcase
  end

  assign cur_epoch  = epoch_r[page_r];
  assign cur_pte    = (rd_data.tag == cur_epoch) ? rd_data.pte : '0;
  assign pte_ppn    = cur_pte[53:10];
  assign ppn_diff   = pte_ppn - table_base_ppn;
  assign outside    = ppn_diff >= PAGES_PPN;
  assign nf_page    = nf_r[PAGE_W-1:0];
  assign pool_empty = nf_r == POOL_END;
  assign alloc_pte  = {10'd0, table_base_ppn + {{(PPN_W-CNT_W){1'b0}}, nf_r}, 9'd0, 1'b1};
  assign leaf_pte   = {10'd0, pa_ppn_r, 1'b0, flags_r[8:1], 1'b1};

  always_comb begin
    state_nxt      = state_r;
    op_nxt         = op_r;
    va_nxt         = va_r;
    pa_ppn_nxt     = pa_ppn_r;
    flags_nxt      = flags_r;
    level_nxt      = level_r;
    page_nxt       = page_r;
    nf_nxt         = nf_r;
    epoch_nxt      = epoch_r;
    out_strobe_nxt = 1'b0;
    out_item_nxt   = out_item_r;
    mem_req        = '0;
    mem_req.addr   = {page_r, vpn_sel};
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          op_nxt     = in_item.operation;
          va_nxt     = in_item.virt_addr;
          pa_ppn_nxt = in_item.phys_addr_in[PA_W-1:OFS_W];
          flags_nxt  = in_item.perm_flags;
          level_nxt  = LVL_TOP;
          page_nxt   = '0;
          if (in_item.operation == OP_TRANSLATE || in_item.operation == OP_MAP ||
              in_item.operation == OP_UNMAP) begin
            state_nxt = S_READ;
          end else begin
            out_strobe_nxt = 1'b1;
            out_item_nxt   = '{status: ST_OK, phys_addr_out: '0};
          end
        end
      end
      S_READ: begin
        mem_req.en = 1'b1;
        if (level_r == '0 && op_r != OP_TRANSLATE) begin
          mem_req.we       = 1'b1;
          mem_req.data.tag = cur_epoch;
          mem_req.data.pte = (op_r == OP_MAP) ? leaf_pte : '0;
          out_strobe_nxt   = 1'b1;
          out_item_nxt     = '{status: ST_OK, phys_addr_out: '0};
          state_nxt        = S_IDLE;
        end else begin
          state_nxt = S_CHECK;
        end
      end
      S_CHECK: begin
        if (level_r == '0) begin
          out_strobe_nxt = 1'b1;
          state_nxt      = S_IDLE;
          if (cur_pte[0]) begin
            out_item_nxt = '{status: ST_OK, phys_addr_out: {pte_ppn, va_r[OFS_W-1:0]}};
          end else begin
            out_item_nxt = '{status: ST_UNMAPPED, phys_addr_out: '0};
          end
        end else if (!cur_pte[0]) begin
          if (op_r != OP_MAP) begin
            out_strobe_nxt = 1'b1;
            out_item_nxt   = '{status: ST_UNMAPPED, phys_addr_out: '0};
            state_nxt      = S_IDLE;
          end else if (pool_empty) begin
            out_strobe_nxt = 1'b1;
            out_item_nxt   = '{status: ST_NOPAGE, phys_addr_out: '0};
            state_nxt      = S_IDLE;
          end else begin
            // new table page: flip its epoch so old contents read as zero
            epoch_nxt[nf_page] = ~epoch_r[nf_page];
            mem_req.en         = 1'b1;
            mem_req.we         = 1'b1;
            mem_req.data.tag   = (nf_page == page_r) ? ~cur_epoch : cur_epoch;
            mem_req.data.pte   = alloc_pte;
            page_nxt           = nf_page;
            nf_nxt             = nf_r + 1'b1;
            level_nxt          = level_r - 1'b1;
            state_nxt          = S_READ;
          end
        end else if (outside) begin
          out_strobe_nxt = 1'b1;
          out_item_nxt   = '{status: ST_OUTSIDE, phys_addr_out: '0};
          state_nxt      = S_IDLE;
        end else begin
          page_nxt  = ppn_diff[PAGE_W-1:0];
          level_nxt = level_r - 1'b1;
          state_nxt = S_READ;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      nf_r         <= CNT_W'(1);
      epoch_r      <= '0;
      out_strobe_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      nf_r         <= nf_nxt;
      epoch_r      <= epoch_nxt;
      out_strobe_r <= out_strobe_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r       <= op_nxt;
    va_r       <= va_nxt;
    pa_ppn_r   <= pa_ppn_nxt;
    flags_r    <= flags_nxt;
    level_r    <= level_nxt;
    page_r     <= page_nxt;
    out_item_r <= out_item_nxt;
  end

  assign out_strobe = out_strobe_r;
  assign out_item   = out_item_r;

  a_pool_bound: assert property (@(posedge clk) disable iff (!rst_n)
    nf_r <= POOL_END)
    else $error("table pool counter past end");

  a_idle_no_mem: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_IDLE |-> !mem_req.en)
    else $error("memory request while idle");

  a_nf_step: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) && nf_r != $past(nf_r) |-> nf_r == $past(nf_r) + 1'b1)
    else $error("table pool counter moved by more than one");

  a_nopage: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe_r && out_item_r.status == ST_NOPAGE |-> nf_r == POOL_END)
    else $error("no free table reported with pool left");

  a_accept_path: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> state_r == S_READ || out_strobe_r)
    else $error("accepted request went nowhere");

endmodule

`default_nettype wire
